/* rtl/rrqs_pkg.sv */
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types, codes and defaults of the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

  localparam int DEF_TASK_SLOTS = 16;
  localparam int DEF_SLICE_BITS = 16;
  localparam logic [15:0] SLICE_LEN_RESET = 16'd10;
  localparam logic [4:0] CNT_MAX = 5'd31;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_YIELD = 3'd1,
    ACT_ADD   = 3'd2,
    ACT_REM   = 3'd3,
    ACT_SET   = 3'd4
  } act_t;

  typedef enum logic [2:0] {
    ST_READY   = 3'd0,
    ST_RUNNING = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_ZOMBIE  = 3'd3,
    ST_STOPPED = 3'd4
  } tstate_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [2:0]  new_state;
    logic [31:0] frame_in;
    logic [31:0] space_in;
  } in_data_t;

  typedef struct packed {
    logic [31:0] frame_out;
    logic        switched;
    logic [31:0] space_out;
    logic        current_valid;
    logic [3:0]  current_index;
    logic [4:0]  ready_count;
  } out_data_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MISC,
    OP_CHECK,
    OP_FIND,
    OP_SAVE,
    OP_UPD,
    OP_SCAN,
    OP_RDNX,
    OP_SWAP,
    OP_CLR,
    OP_COUNT,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       have;
    logic       idx_present;
    logic       idx_runnable;
    logic       idx_last;
    logic       idx_is_cur;
    logic       expired;
    logic       out_free;
  } dp_stat_t;

endpackage

/* rtl/rrqs_ctrl.sv */
// ----------------------------------------------------------------------------
// rrqs_ctrl
// Sequencer that steps the datapath through one transaction at a time.
// ----------------------------------------------------------------------------
module rrqs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrqs_pkg::dp_stat_t stat,
  output rrqs_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ENTRY, S_FIND, S_SAVE, S_UPD, S_TEST,
    S_SCAN, S_RDNX, S_SWAP, S_CLR, S_COUNT, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rrqs_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = rrqs_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.act)
          rrqs_pkg::ACT_TICK, rrqs_pkg::ACT_YIELD: begin
            cmd.op    = rrqs_pkg::OP_CHECK;
            state_nxt = S_ENTRY;
          end
          default: begin
            cmd.op    = rrqs_pkg::OP_MISC;
            state_nxt = S_CLR;
          end
        endcase
      end
      S_ENTRY: begin
        if (stat.have) begin
          cmd.op    = rrqs_pkg::OP_SAVE;
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        cmd.op = rrqs_pkg::OP_FIND;
        if (stat.idx_present) begin
          state_nxt = S_SAVE;
        end else if (stat.idx_last) begin
          state_nxt = S_CLR;
        end
      end
      S_SAVE: begin
        cmd.op    = rrqs_pkg::OP_SAVE;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.op    = rrqs_pkg::OP_UPD;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        state_nxt = stat.expired ? S_SCAN : S_CLR;
      end
      S_SCAN: begin
        cmd.op = rrqs_pkg::OP_SCAN;
        // Reaching the current slot again means a full lap without a switch.
        if (stat.idx_is_cur) begin
          state_nxt = S_CLR;
        end else if (stat.idx_runnable) begin
          state_nxt = S_RDNX;
        end
      end
      S_RDNX: begin
        cmd.op    = rrqs_pkg::OP_RDNX;
        state_nxt = S_SWAP;
      end
      S_SWAP: begin
        cmd.op    = rrqs_pkg::OP_SWAP;
        state_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.op    = rrqs_pkg::OP_CLR;
        state_nxt = S_COUNT;
      end
      S_COUNT: begin
        cmd.op = rrqs_pkg::OP_COUNT;
        if (stat.idx_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = rrqs_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/rrqs_dp.sv */
// ----------------------------------------------------------------------------
// rrqs_dp
// Slot table, per-slot memories, scan index, counters and result register.
// ----------------------------------------------------------------------------
module rrqs_dp #(
  parameter int TASK_SLOTS = rrqs_pkg::DEF_TASK_SLOTS,
  parameter int SLICE_BITS = rrqs_pkg::DEF_SLICE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rrqs_pkg::dp_cmd_t     cmd,
  output rrqs_pkg::dp_stat_t    stat,
  input  rrqs_pkg::in_data_t    in_data,
  input  logic [SLICE_BITS-1:0] reload,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rrqs_pkg::out_data_t   out_data
);

  localparam int IW = $clog2(TASK_SLOTS);
  localparam logic [IW-1:0] IDX_LAST = IW'(TASK_SLOTS - 1);

  // Slot table state with reset values.
  logic              pres_r [TASK_SLOTS];
  rrqs_pkg::tstate_t st_r   [TASK_SLOTS];

  // Per-slot payload stores; a slot is always added before any of these is read.
  logic [SLICE_BITS-1:0] slice_mem [TASK_SLOTS];
  logic [31:0]           frame_mem [TASK_SLOTS];
  logic [31:0]           space_mem [TASK_SLOTS];

  logic [2:0]  act_r;
  logic [3:0]  slot_r;
  logic [2:0]  nst_r;
  logic [31:0] frame_r, space_r;
  logic [IW-1:0] cur_r, idx_r;
  logic        have_r, fresh_r, yz_r, expired_r;
  logic [SLICE_BITS-1:0] slice_q;
  logic [31:0] frame_q, space_q;
  logic [31:0] fout_r, sp_r;
  logic        sw_r;
  logic [4:0]  cnt_r;
  logic        out_valid_r;
  rrqs_pkg::out_data_t out_data_r;

  logic          slot_ok;
  logic [IW-1:0] slot_idx, idx_inc, cur_inc;
  logic          cur_run, idx_run;
  logic [SLICE_BITS-1:0] s_cur, s_dec;

  logic                  sl_we, fr_we, sp_we;
  logic [IW-1:0]         sl_wa, fr_wa, rd_a;
  logic [SLICE_BITS-1:0] sl_wd;

  assign slot_ok  = (32'(slot_r) < TASK_SLOTS);
  assign slot_idx = IW'(slot_r);
  assign idx_inc  = (idx_r == IDX_LAST) ? '0 : idx_r + IW'(1);
  assign cur_inc  = (cur_r == IDX_LAST) ? '0 : cur_r + IW'(1);
  assign cur_run  = pres_r[cur_r] &&
                    (st_r[cur_r] == rrqs_pkg::ST_READY || st_r[cur_r] == rrqs_pkg::ST_RUNNING);
  assign idx_run  = pres_r[idx_r] &&
                    (st_r[idx_r] == rrqs_pkg::ST_READY || st_r[idx_r] == rrqs_pkg::ST_RUNNING);

  assign s_cur = fresh_r ? reload : (yz_r ? '0 : slice_q);
  assign s_dec = (s_cur != '0) ? s_cur - SLICE_BITS'(1) : '0;

  assign stat.act          = act_r;
  assign stat.have         = have_r;
  assign stat.idx_present  = pres_r[idx_r];
  assign stat.idx_runnable = idx_run;
  assign stat.idx_last     = (idx_r == IDX_LAST);
  assign stat.idx_is_cur   = (idx_r == cur_r);
  assign stat.expired      = expired_r;
  assign stat.out_free     = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Memory port selection.
  always_comb begin
    sl_we = 1'b0;
    sl_wa = cur_r;
    sl_wd = reload;
    fr_we = 1'b0;
    fr_wa = cur_r;
    sp_we = 1'b0;
    rd_a  = cur_r;
    case (cmd.op)
      rrqs_pkg::OP_MISC: begin
        if (act_r == rrqs_pkg::ACT_ADD && slot_ok) begin
          sl_we = 1'b1;
          sl_wa = slot_idx;
          fr_we = 1'b1;
          fr_wa = slot_idx;
          sp_we = 1'b1;
        end
      end
      rrqs_pkg::OP_CHECK: begin
        // A yield empties the current slice even when that task is then dropped.
        if (act_r == rrqs_pkg::ACT_YIELD && have_r) begin
          sl_we = 1'b1;
          sl_wd = '0;
        end
      end
      rrqs_pkg::OP_SAVE: fr_we = 1'b1;
      rrqs_pkg::OP_UPD: begin
        sl_we = 1'b1;
        sl_wd = (s_dec != '0) ? s_dec : reload;
      end
      rrqs_pkg::OP_RDNX: rd_a = idx_r;
      rrqs_pkg::OP_SWAP: begin
        if (frame_q != '0 && slice_q == '0) begin
          sl_we = 1'b1;
          sl_wa = idx_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sl_we) begin
      slice_mem[sl_wa] <= sl_wd;
    end
    if (fr_we) begin
      frame_mem[fr_wa] <= frame_r;
    end
    if (sp_we) begin
      space_mem[slot_idx] <= space_r;
    end
    if (cmd.op == rrqs_pkg::OP_SAVE || cmd.op == rrqs_pkg::OP_RDNX) begin
      slice_q <= slice_mem[rd_a];
    end
    if (cmd.op == rrqs_pkg::OP_RDNX) begin
      frame_q <= frame_mem[rd_a];
      space_q <= space_mem[rd_a];
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    case (cmd.op)
      rrqs_pkg::OP_LOAD: begin
        act_r   <= in_data.action;
        slot_r  <= in_data.slot;
        nst_r   <= in_data.new_state;
        frame_r <= in_data.frame_in;
        space_r <= in_data.space_in;
        fout_r  <= '0;
        sp_r    <= '0;
      end
      rrqs_pkg::OP_CHECK: begin
        fout_r  <= frame_r;
        idx_r   <= '0;
        fresh_r <= 1'b0;
        yz_r    <= (act_r == rrqs_pkg::ACT_YIELD) && have_r;
      end
      rrqs_pkg::OP_FIND: begin
        if (pres_r[idx_r]) begin
          fresh_r <= 1'b1;
        end else begin
          idx_r <= idx_inc;
        end
      end
      rrqs_pkg::OP_UPD: begin
        expired_r <= (s_dec == '0);
        idx_r     <= cur_inc;
      end
      rrqs_pkg::OP_SCAN: begin
        if (!idx_run) begin
          idx_r <= idx_inc;
        end
      end
      rrqs_pkg::OP_SWAP: begin
        if (frame_q != '0) begin
          fout_r <= frame_q;
          sp_r   <= space_q;
        end
      end
      rrqs_pkg::OP_CLR: begin
        idx_r <= '0;
      end
      rrqs_pkg::OP_COUNT: begin
        idx_r <= idx_inc;
      end
      rrqs_pkg::OP_OUT: begin
        out_data_r.frame_out     <= fout_r;
        out_data_r.switched      <= sw_r;
        out_data_r.space_out     <= sp_r;
        out_data_r.current_valid <= have_r;
        out_data_r.current_index <= 4'(cur_r);
        out_data_r.ready_count   <= cnt_r;
      end
      default: ;
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        pres_r[i] <= 1'b0;
        st_r[i]   <= rrqs_pkg::ST_STOPPED;
      end
      cur_r       <= '0;
      have_r      <= 1'b0;
      sw_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        rrqs_pkg::OP_LOAD: sw_r <= 1'b0;
        rrqs_pkg::OP_MISC: begin
          if (slot_ok) begin
            case (act_r)
              rrqs_pkg::ACT_ADD: begin
                pres_r[slot_idx] <= 1'b1;
                if (nst_r == rrqs_pkg::ST_ZOMBIE || nst_r == rrqs_pkg::ST_STOPPED) begin
                  st_r[slot_idx] <= rrqs_pkg::tstate_t'(nst_r);
                end else begin
                  st_r[slot_idx] <= rrqs_pkg::ST_READY;
                end
              end
              rrqs_pkg::ACT_REM: st_r[slot_idx] <= rrqs_pkg::ST_STOPPED;
              rrqs_pkg::ACT_SET: begin
                if (nst_r <= rrqs_pkg::ST_STOPPED) begin
                  st_r[slot_idx] <= rrqs_pkg::tstate_t'(nst_r);
                end
              end
              default: ;
            endcase
          end
        end
        rrqs_pkg::OP_CHECK: begin
          if (have_r && !cur_run) begin
            have_r <= 1'b0;
          end
        end
        rrqs_pkg::OP_FIND: begin
          if (pres_r[idx_r]) begin
            cur_r        <= idx_r;
            have_r       <= 1'b1;
            st_r[idx_r]  <= rrqs_pkg::ST_RUNNING;
          end
        end
        rrqs_pkg::OP_SWAP: begin
          if (frame_q != '0) begin
            if (st_r[cur_r] == rrqs_pkg::ST_RUNNING) begin
              st_r[cur_r] <= rrqs_pkg::ST_READY;
            end
            st_r[idx_r] <= rrqs_pkg::ST_RUNNING;
            cur_r       <= idx_r;
            sw_r        <= 1'b1;
          end
        end
        rrqs_pkg::OP_CLR: cnt_r <= '0;
        rrqs_pkg::OP_COUNT: begin
          if (idx_run && cnt_r != rrqs_pkg::CNT_MAX) begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        rrqs_pkg::OP_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // A current task is always a slot that has been added.
  a_cur_present: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> pres_r[cur_r])
    else $error("current task slot is not present");

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> (32'(cur_r) < TASK_SLOTS))
    else $error("current slot index out of range");

  a_sw_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.switched) |-> out_data_r.current_valid)
    else $error("switch reported without a current task");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rrqs_pkg::OP_OUT) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

endmodule

/* rtl/round_robin_quantum_scheduler.sv */
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler
// Round-robin time-slice scheduler over a table of task slots.
//
//   Channel  Ports            Moves
//   input    in_valid/ready   one action transaction (tick, yield, add, ...)
//   result   out_valid/ready  one result transaction per action
//   config   psel/penable/... slice_length register at byte address 0
//
// One transaction is worked on at a time; the next is taken once its result
// is in the output register, even if that result has not been taken yet.
// Add, remove and set-state go straight to the ready count walk.
// A tick or yield may run a search for the lowest present slot, a circular
// scan for the next runnable slot and the ready count walk, each one slot
// per cycle.
// Reset is synchronous and clears the slot table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler #(
  parameter int TASK_SLOTS = rrqs_pkg::DEF_TASK_SLOTS,
  parameter int SLICE_BITS = rrqs_pkg::DEF_SLICE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrqs_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rrqs_pkg::out_data_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [15:0]        slice_len_r;
  rrqs_pkg::dp_cmd_t  cmd;
  rrqs_pkg::dp_stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, slice_len_r} : 32'd0;

  // Zero writes leave the reload value unchanged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_len_r <= rrqs_pkg::SLICE_LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0 &&
                 pwdata[15:0] != 16'd0) begin
      slice_len_r <= pwdata[15:0];
    end
  end

  rrqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrqs_dp #(
    .TASK_SLOTS (TASK_SLOTS),
    .SLICE_BITS (SLICE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .reload    (SLICE_BITS'(slice_len_r)),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
